// ===== hdl/rtnt_pkg.sv =====
`default_nettype none
package rtnt_pkg;

	localparam int unsigned RTNT_ENTRIES = 16;

	localparam int unsigned MODE_W   = 2;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned POINTS_W = 32;
	localparam int unsigned LEVEL_W  = 8;
	localparam int unsigned LINES_W  = 16;
	localparam int unsigned DATE_W   = 32;
	localparam int unsigned RANK_W   = 4;

	// Stored entry words: key in the top bits.
	localparam int unsigned TIME_WORD_W  = TIME_W + LEVEL_W + DATE_W;
	localparam int unsigned SCORE_WORD_W = POINTS_W + LEVEL_W + LINES_W + TIME_W + DATE_W;

	localparam logic [MODE_W-1:0] MODE_TIME  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SCORE = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK_RD,
		ST_CHK_CMP,
		ST_STEP,
		ST_CMP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0]          mode;
		logic [TIME_W-1:0]          time_ms;
		logic signed [POINTS_W-1:0] points;
		logic [LEVEL_W-1:0]         level_reached;
		logic [LINES_W-1:0]         lines_done;
		logic [DATE_W-1:0]          date_stamp;
	} rec_t;

	typedef struct packed {
		logic rd;
		logic wr_time;
		logic wr_score;
		logic wr_shift;
	} mem_en_t;

endpackage
`default_nettype wire

// ===== hdl/rtnt_rec_if.sv =====
`default_nettype none
interface rtnt_rec_if;
	import rtnt_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [MODE_W-1:0]          mode;
	logic                       run_complete;
	logic [TIME_W-1:0]          time_ms;
	logic signed [POINTS_W-1:0] points;
	logic [LEVEL_W-1:0]         level_reached;
	logic [LINES_W-1:0]         lines_done;
	logic [DATE_W-1:0]          date_stamp;

	modport source (
		output valid, mode, run_complete, time_ms, points, level_reached, lines_done,
			date_stamp,
		input  ready
	);
	modport sink (
		input  valid, mode, run_complete, time_ms, points, level_reached, lines_done,
			date_stamp,
		output ready
	);
endinterface
`default_nettype wire

// ===== hdl/rtnt_res_if.sv =====
`default_nettype none
interface rtnt_res_if;
	import rtnt_pkg::*;

	logic              valid;
	logic              ready;
	logic              accepted;
	logic [RANK_W-1:0] rank;

	modport source (output valid, accepted, rank, input ready);
	modport sink (input valid, accepted, rank, output ready);
endinterface
`default_nettype wire

// ===== hdl/rtnt_table_mem.sv =====
`default_nettype none
module rtnt_table_mem #(
	parameter int unsigned WORD_W = 72,
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned AW     = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [WORD_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [WORD_W-1:0] rdata
);
	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/rtnt_ctrl.sv =====
`default_nettype none
module rtnt_ctrl #(
	parameter int unsigned N  = 16,
	parameter int unsigned AW = 4,
	parameter int unsigned CW = 5
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	rtnt_rec_if.sink                                  rec,
	rtnt_res_if.source                                res,
	input  wire logic [rtnt_pkg::TIME_W-1:0]          time_key,
	input  wire logic signed [rtnt_pkg::POINTS_W-1:0] score_key,
	output rtnt_pkg::rec_t                            rec_q,
	output rtnt_pkg::mem_en_t                         men,
	output logic      [AW-1:0]                        wr_addr,
	output logic      [AW-1:0]                        rd_addr
);
	import rtnt_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(N - 1);
	localparam logic [CW-1:0] FULL = CW'(N);

	state_t            state_q, state_d;
	logic [CW-1:0]     time_count_q, score_count_q;
	logic [AW-1:0]     idx_q, pos_q;
	logic              acc_q;
	logic              res_valid_q, res_acc_q;
	logic [RANK_W-1:0] res_rank_q;

	logic [CW-1:0] in_count, act_count;
	logic          rec_ok, beats, out_free, wr_any, insert_done;

	always_comb begin
		in_count  = (rec.mode == MODE_TIME) ? time_count_q : score_count_q;
		act_count = (rec_q.mode == MODE_TIME) ? time_count_q : score_count_q;
		rec_ok    = ((rec.mode == MODE_TIME) && rec.run_complete) ||
			((rec.mode == MODE_SCORE) && (rec.points > 0));
		// Strict compare: on a tie the new item lands after the equal ones.
		beats     = (rec_q.mode == MODE_TIME) ? (rec_q.time_ms < time_key)
			: (rec_q.points > score_key);
		out_free  = !res_valid_q || res.ready;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (rec.valid) begin
					if (!rec_ok) begin
						state_d = ST_FIN;
					end else if (in_count == FULL) begin
						state_d = ST_CHK_RD;
					end else begin
						state_d = ST_STEP;
					end
				end
			end
			ST_CHK_RD:  state_d = ST_CHK_CMP;
			ST_CHK_CMP: state_d = beats ? ST_STEP : ST_FIN;
			ST_STEP:    state_d = (idx_q == '0) ? ST_FIN : ST_CMP;
			ST_CMP:     state_d = beats ? ST_STEP : ST_FIN;
			ST_FIN:     state_d = out_free ? ST_IDLE : ST_FIN;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs: walk up from the bottom, moving each beaten entry down one slot.
	// A write at idx is followed by a read at idx-2, so accesses never collide.
	always_comb begin
		rec.ready    = (state_q == ST_IDLE);
		men.rd       = (state_q == ST_CHK_RD) || ((state_q == ST_STEP) && (idx_q != '0));
		rd_addr      = (state_q == ST_CHK_RD) ? LAST : AW'(idx_q - 1'b1);
		wr_any       = ((state_q == ST_STEP) && (idx_q == '0)) || (state_q == ST_CMP);
		men.wr_shift = (state_q == ST_CMP) && beats;
		men.wr_time  = wr_any && (rec_q.mode == MODE_TIME);
		men.wr_score = wr_any && (rec_q.mode == MODE_SCORE);
		wr_addr      = idx_q;
		insert_done  = wr_any && !men.wr_shift;
		res.valid    = res_valid_q;
		res.accepted = res_acc_q;
		res.rank     = res_rank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			time_count_q  <= '0;
			score_count_q <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (insert_done && (act_count != FULL)) begin
				if (rec_q.mode == MODE_TIME) begin
					time_count_q <= CW'(time_count_q + 1'b1);
				end else begin
					score_count_q <= CW'(score_count_q + 1'b1);
				end
			end
			if ((state_q == ST_FIN) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rec_q.mode          <= rec.mode;
				rec_q.time_ms       <= rec.time_ms;
				rec_q.points        <= rec.points;
				rec_q.level_reached <= rec.level_reached;
				rec_q.lines_done    <= rec.lines_done;
				rec_q.date_stamp    <= rec.date_stamp;
				acc_q               <= 1'b0;
				pos_q               <= '0;
				idx_q               <= (in_count == FULL) ? LAST : AW'(in_count);
			end
			ST_CMP: begin
				if (beats) begin
					idx_q <= AW'(idx_q - 1'b1);
				end
			end
			default: ;
		endcase
		if (insert_done) begin
			acc_q <= 1'b1;
			pos_q <= idx_q;
		end
		if ((state_q == ST_FIN) && out_free) begin
			res_acc_q  <= acc_q;
			res_rank_q <= RANK_W'(pos_q);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/ranked_top_n_table_insert.sv =====
// Ranked top-N table insert.
// Channel rec carries one record: mode 0 goes to the time table (ascending
// time_ms), mode 1 to the score table (descending points); other modes, an
// incomplete timed run or a score that is not positive are rejected.
// Channel res returns one item per record: accepted and the rank it took
// (0 best, 0 when rejected). A full table drops its last entry on insert.
// Each table lives in one synchronous RAM; a record walks up from the
// bottom, one read-compare-write step (ST_STEP, ST_CMP) per entry that moves.
// The result is registered on leaving ST_FIN: a record rejected outright goes
// there straight from ST_IDLE, an inserted one after ST_STEP and ST_CMP for
// each entry moved, preceded by ST_CHK_RD and ST_CHK_CMP when the table is full.
// rec.ready rises with res.valid.
// One record is in work at a time; rec.ready is high only between records.
// The result sits in an output register, so a new record is taken while
// the receiver stalls; a finished record waits until that register frees.
// Reset empties both tables (counts cleared); no RAM clearing is needed
// since only entries below the count are ever read.
`default_nettype none
module ranked_top_n_table_insert #(
	parameter int unsigned TABLE_ENTRIES = rtnt_pkg::RTNT_ENTRIES
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rtnt_rec_if.sink   rec,
	rtnt_res_if.source res
);
	import rtnt_pkg::*;

	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

	rec_t    rec_q;
	mem_en_t men;
	logic [AW-1:0] wr_addr, rd_addr;

	logic [TIME_WORD_W-1:0]  time_rdata, time_wdata;
	logic [SCORE_WORD_W-1:0] score_rdata, score_wdata;
	logic [TIME_W-1:0]          time_key;
	logic signed [POINTS_W-1:0] score_key;

	always_comb begin
		time_wdata  = men.wr_shift ? time_rdata
			: {rec_q.time_ms, rec_q.level_reached, rec_q.date_stamp};
		score_wdata = men.wr_shift ? score_rdata
			: {rec_q.points, rec_q.level_reached, rec_q.lines_done, rec_q.time_ms,
				rec_q.date_stamp};
		time_key  = time_rdata[TIME_WORD_W-1 -: TIME_W];
		score_key = $signed(score_rdata[SCORE_WORD_W-1 -: POINTS_W]);
	end

	rtnt_ctrl #(
		.N  (TABLE_ENTRIES),
		.AW (AW),
		.CW (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (rec),
		.res       (res),
		.time_key  (time_key),
		.score_key (score_key),
		.rec_q     (rec_q),
		.men       (men),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	rtnt_table_mem #(
		.WORD_W (TIME_WORD_W),
		.DEPTH  (TABLE_ENTRIES),
		.AW     (AW)
	) u_time_mem (
		.clk   (clk),
		.we    (men.wr_time),
		.waddr (wr_addr),
		.wdata (time_wdata),
		.re    (men.rd),
		.raddr (rd_addr),
		.rdata (time_rdata)
	);

	rtnt_table_mem #(
		.WORD_W (SCORE_WORD_W),
		.DEPTH  (TABLE_ENTRIES),
		.AW     (AW)
	) u_score_mem (
		.clk   (clk),
		.we    (men.wr_score),
		.waddr (wr_addr),
		.wdata (score_wdata),
		.re    (men.rd),
		.raddr (rd_addr),
		.rdata (score_rdata)
	);
endmodule
`default_nettype wire

// ===== hdl/rtnt_checker.sv =====
`default_nettype none
module rtnt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rec_valid,
	input wire logic       rec_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic       res_accepted,
	input wire logic [3:0] res_rank
);
	// One record in work at a time: no second item right after an accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_ready |=> !rec_ready)
		else $error("rec taken on two consecutive cycles");

	// Hold a stalled result.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_accepted) && $stable(res_rank))
		else $error("stalled result changed");

	a_reject_rank: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_accepted |-> res_rank == 4'd0)
		else $error("rejected item reports nonzero rank");

	// A result shows only after its record has passed ST_FIN into the result register.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_ready && !res_valid |=> !res_valid)
		else $error("result appeared too early");
endmodule

bind ranked_top_n_table_insert rtnt_checker u_rtnt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rec_valid    (rec.valid),
	.rec_ready    (rec.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_accepted (res.accepted),
	.res_rank     (res.rank)
);
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rtnt_pkg::*;

	localparam logic [MODE_W-1:0] MODE_RSVD_2 = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RSVD_3 = 2'd3;

	typedef struct {
		logic [MODE_W-1:0]          mode;
		logic                       run_complete;
		logic [TIME_W-1:0]          time_ms;
		logic signed [POINTS_W-1:0] points;
		logic [LEVEL_W-1:0]         level_reached;
		logic [LINES_W-1:0]         lines_done;
		logic [DATE_W-1:0]          date_stamp;
	} record_t;

	typedef struct {
		logic              accepted;
		logic [RANK_W-1:0] rank;
	} placement_t;

	// Only the keys decide the placement, so only the keys are tracked.
	class ranked_tables;
		logic [TIME_W-1:0]          best_times[$];
		logic signed [POINTS_W-1:0] best_points[$];
		placement_t                 placements_due[$];
		int unsigned                mismatches;

		function void note_record(record_t r);
			placement_t p;
			int pos;
			p.accepted = 1'b0;
			p.rank = '0;
			pos = -1;
			if (r.mode == MODE_TIME && r.run_complete) begin
				// strict beat: a tie lands after the equal entries
				foreach (best_times[i])
					if (pos < 0 && r.time_ms < best_times[i])
						pos = i;
				if (pos < 0 && best_times.size() < RTNT_ENTRIES)
					pos = best_times.size();
				if (pos >= 0) begin
					best_times.insert(pos, r.time_ms);
					if (best_times.size() > RTNT_ENTRIES)
						void'(best_times.pop_back());
				end
			end else if (r.mode == MODE_SCORE && r.points > 0) begin
				foreach (best_points[i])
					if (pos < 0 && r.points > best_points[i])
						pos = i;
				if (pos < 0 && best_points.size() < RTNT_ENTRIES)
					pos = best_points.size();
				if (pos >= 0) begin
					best_points.insert(pos, r.points);
					if (best_points.size() > RTNT_ENTRIES)
						void'(best_points.pop_back());
				end
			end
			if (pos >= 0) begin
				p.accepted = 1'b1;
				p.rank = RANK_W'(pos);
			end
			placements_due.push_back(p);
		endfunction

		function void check_result(logic acc, logic [RANK_W-1:0] rk);
			placement_t want;
			if (placements_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, accepted %0b rank %0d", $time, acc, rk);
				return;
			end
			want = placements_due.pop_front();
			if (acc !== want.accepted) begin
				mismatches++;
				$display("%0t: accepted expected %0b actual %0b", $time, want.accepted, acc);
			end
			if (rk !== want.rank) begin
				mismatches++;
				$display("%0t: rank expected %0d actual %0d", $time, want.rank, rk);
			end
		endfunction

		function int outstanding();
			return placements_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rtnt_rec_if rec_if();
	rtnt_res_if res_if();

	ranked_tables board;
	int unsigned  sent;
	logic [TIME_W-1:0]          time_base;
	logic signed [POINTS_W-1:0] score_base;

	ranked_top_n_table_insert u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rec    (rec_if),
		.res    (res_if)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic record_t make_rec(logic [MODE_W-1:0] m, logic done,
			logic [TIME_W-1:0] t, logic signed [POINTS_W-1:0] pts);
		record_t r;
		r.mode = m;
		r.run_complete = done;
		r.time_ms = t;
		r.points = pts;
		r.level_reached = LEVEL_W'($urandom());
		r.lines_done = LINES_W'($urandom());
		r.date_stamp = $urandom();
		return r;
	endfunction

	// Keys drift slowly across a wide window so new records land at every rank,
	// and some copy a stored key to force ties.
	function automatic record_t next_record();
		record_t r;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		r = make_rec(MODE_RSVD_2, 1'b1, $urandom(), $urandom());
		if (roll < 36) begin
			time_base = time_base - $urandom_range(0, 4);
			r.mode = MODE_TIME;
			r.time_ms = time_base + $urandom_range(0, 200);
			if (board.best_times.size() > 0 && $urandom_range(0, 6) == 0)
				r.time_ms = board.best_times[$urandom_range(0, board.best_times.size() - 1)];
		end else if (roll < 72) begin
			score_base = score_base + $urandom_range(0, 4);
			r.mode = MODE_SCORE;
			r.points = score_base + $urandom_range(0, 200);
			if (board.best_points.size() > 0 && $urandom_range(0, 6) == 0)
				r.points = board.best_points[$urandom_range(0, board.best_points.size() - 1)];
		end else if (roll < 80) begin
			r.mode = $urandom_range(0, 1) ? MODE_RSVD_3 : MODE_RSVD_2;
			r.run_complete = 1'($urandom());
		end else if (roll < 89) begin
			r.mode = MODE_TIME;
			r.run_complete = 1'b0;
		end else begin
			r.mode = MODE_SCORE;
			r.run_complete = 1'($urandom());
			r.points = $urandom_range(0, 2) == 0 ? '0 : {1'b1, 31'($urandom())};
		end
		return r;
	endfunction

	task automatic send_item(input record_t r);
		int unsigned gap;
		gap = ((sent / 60) % 4 == 0) ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			rec_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rec_if.valid <= 1'b1;
		rec_if.mode <= r.mode;
		rec_if.run_complete <= r.run_complete;
		rec_if.time_ms <= r.time_ms;
		rec_if.points <= r.points;
		rec_if.level_reached <= r.level_reached;
		rec_if.lines_done <= r.lines_done;
		rec_if.date_stamp <= r.date_stamp;
		do @(posedge clk); while (!rec_if.ready);
		board.note_record(r);
		sent++;
	endtask

	// Result side: random stalls, stall-free stretches, and one long hold
	// so the block backs up into its input.
	initial begin
		int unsigned taken;
		int unsigned stall;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (taken == 300)
				stall = 300;
			else if ((taken / 70) % 4 == 1)
				stall = 0;
			else
				stall = $urandom_range(0, 12);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			board.check_result(res_if.accepted, res_if.rank);
			taken++;
		end
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		record_t r;
		board = new();
		sent = 0;
		time_base = 32'hFFFF_0000;
		score_base = 32'sh100;
		arst_n = 1'b0;
		rec_if.valid = 1'b0;
		rec_if.mode = '0;
		rec_if.run_complete = 1'b0;
		rec_if.time_ms = '0;
		rec_if.points = '0;
		rec_if.level_reached = '0;
		rec_if.lines_done = '0;
		rec_if.date_stamp = '0;
		res_if.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// unknown modes, fields at their extremes
		r = make_rec(MODE_RSVD_2, 1'b1, '1, 32'sh7FFF_FFFF);
		r.level_reached = '1;
		r.lines_done = '1;
		r.date_stamp = '1;
		send_item(r);
		r = make_rec(MODE_RSVD_3, 1'b0, '0, '0);
		r.level_reached = '0;
		r.lines_done = '0;
		r.date_stamp = '0;
		send_item(r);
		// incomplete timed run
		send_item(make_rec(MODE_TIME, 1'b0, '0, 32'sh8000_0000));
		// time table: empty insert, tie, better, tie
		r = make_rec(MODE_TIME, 1'b1, '1, '0);
		r.level_reached = '1;
		r.lines_done = '1;
		r.date_stamp = '1;
		send_item(r);
		send_item(make_rec(MODE_TIME, 1'b1, '1, '0));
		r = make_rec(MODE_TIME, 1'b1, 32'hFFFF_FFF0, '0);
		r.level_reached = '0;
		r.lines_done = '0;
		r.date_stamp = '0;
		send_item(r);
		send_item(make_rec(MODE_TIME, 1'b1, 32'hFFFF_FFF0, '0));
		// score not positive
		send_item(make_rec(MODE_SCORE, 1'b1, '0, '0));
		send_item(make_rec(MODE_SCORE, 1'b1, '1, 32'sh8000_0000));
		send_item(make_rec(MODE_SCORE, 1'b0, '0, -32'sd1));
		// score table: smallest positive, tie, better, better, tie
		send_item(make_rec(MODE_SCORE, 1'b0, '0, 32'sd1));
		send_item(make_rec(MODE_SCORE, 1'b1, '1, 32'sd1));
		send_item(make_rec(MODE_SCORE, 1'b1, '0, 32'sd2));
		send_item(make_rec(MODE_SCORE, 1'b1, '0, 32'sh100));
		send_item(make_rec(MODE_SCORE, 1'b1, '0, 32'sh100));

		while (sent < 900)
			send_item(next_record());
		@(negedge clk);
		rec_if.valid <= 1'b0;

		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (board.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/rtnt_pkg.sv
hdl/rtnt_rec_if.sv
hdl/rtnt_res_if.sv
hdl/rtnt_table_mem.sv
hdl/rtnt_ctrl.sv
hdl/ranked_top_n_table_insert.sv
hdl/rtnt_checker.sv
tb/tb.sv
